>>> hw/rtl/cwpg_pkg.sv
// Package for the collinear word and phrase grouper.
// Holds request and response types, sequencer states and boundary codes.
// No dependencies.
`default_nettype none
package cwpg_pkg;

   localparam int WIN_RADIUS = 2;
   localparam int WIN_LEN    = 2 * WIN_RADIUS + 1;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = 16;
   localparam int POS_W      = $clog2(WIN_LEN);
   localparam int LAG_W      = $clog2(WIN_RADIUS + 1);
   localparam int SUM_W      = COORD_W + $clog2(WIN_LEN);
   localparam int CNT_W      = $clog2(WIN_LEN + 1);
   localparam int D2_W       = 2 * COORD_W + 2;
   localparam int S2_W       = 2 * SUM_W;
   localparam int FAC_W      = 5;
   localparam int MUL_A_W    = S2_W;
   localparam int MUL_B_W    = SUM_W;
   localparam int PROD_W     = S2_W + 2 * FAC_W;
   localparam int STEP_W     = 3;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;
   localparam logic [15:0] ANGLE_SPLIT = 16'd12867;
   localparam logic [FAC_W-1:0] FAC_RESET = 5'd10;
   localparam logic [IDX_W-1:0] IDX_SAT = '1;

   localparam logic [1:0] BND_SAME   = 2'd0;
   localparam logic [1:0] BND_WORD   = 2'd1;
   localparam logic [1:0] BND_PHRASE = 2'd2;
   localparam logic [1:0] BND_NONE   = 2'd3;

   typedef struct packed {
      logic [15:0] min_first;
      logic [15:0] min_second;
      logic [15:0] max_first;
      logic [15:0] max_second;
      logic [15:0] line_angle;
      logic        last_box;
   } req_type;

   typedef struct packed {
      logic [15:0] box_index;
      logic [1:0]  boundary;
      logic [15:0] word_index;
      logic [15:0] phrase_index;
      logic        final_result;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] lo0;
      logic [COORD_W-1:0] lo1;
      logic [COORD_W-1:0] hi0;
      logic [COORD_W-1:0] hi1;
   } box_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_LOAD
   } state_type;

endpackage
`default_nettype wire

>>> hw/rtl/collinear_word_phrase_grouper_unit.sv
// Top level of the collinear word and phrase grouper.
// Depends on cwpg_pkg and cwpg_mul.
//
// Boxes of one cluster enter on req_ in line order; each request carries
// the sorted-or-not corners, the line angle and a last-box flag. Results
// leave on rsp_, one per classified box, lagging two boxes; the last box
// flushes the pending ones, so one request gives zero to three results.
// csr_ writes the phrase factor in quarters; it is always ready.
// Each result passes through a setup state that sums heights and finds
// the gap, eight steps of the shared multiplier for the squared
// compares, and a load state that fills the output register. A
// no-successor result skips the multiplier. req_ready is high only
// while the sequencer is idle, so a request waits until all results of
// the request before it are loaded.
// When the receiver stalls, the finished result holds in the output
// register and the sequencer waits before loading the next one.
// Reset (synchronous) empties the output register, clears the box and
// word/phrase counters and sets the factor to 10 (2.5). No clearing pass.
`default_nettype none
module collinear_word_phrase_grouper_unit
   import cwpg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [FAC_W-1:0] csr_data
);
   state_type state_ff, state_in;
   box_type            box_ff [WIN_LEN];
   logic [15:0]        ang_ff [WIN_LEN];
   logic [FAC_W-1:0]   fac_ff;
   logic [IDX_W-1:0]   seen_ff, k_ff, word_ff, phrase_ff;
   logic               last_ff;
   logic [LAG_W-1:0]   lag_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [D2_W-1:0]    d2_ff;
   logic [S2_W-1:0]    s2_ff, lhs_ff;
   logic [1:0]         bnd_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               req_fire, load_fire, out_free;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [POS_W-1:0]   pos_c, old_c, first_c, lastp_c;
   logic [SUM_W-1:0]   sum_c;
   logic [CNT_W-1:0]   cnt_c;
   logic [COORD_W-1:0] dx_c, dy_c, ext_c;
   logic               axis1_c;
   box_type            ba_c, bb_c, new_box;
   logic [1:0]         bnd_c;

   cwpg_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      new_box.lo0 = (req_data.min_first < req_data.max_first) ?
                    req_data.min_first : req_data.max_first;
      new_box.hi0 = (req_data.min_first < req_data.max_first) ?
                    req_data.max_first : req_data.min_first;
      new_box.lo1 = (req_data.min_second < req_data.max_second) ?
                    req_data.min_second : req_data.max_second;
      new_box.hi1 = (req_data.min_second < req_data.max_second) ?
                    req_data.max_second : req_data.min_second;
   end

   // window bounds, height sum and gap for the box being classified
   always_comb begin
      pos_c   = POS_W'(WIN_LEN - 1) - POS_W'(lag_ff);
      old_c   = (k_ff >= IDX_W'(WIN_LEN - 1)) ? '0 :
                POS_W'(WIN_LEN - 1) - POS_W'(k_ff);
      first_c = (pos_c >= POS_W'(WIN_RADIUS)) ? pos_c - POS_W'(WIN_RADIUS) : '0;
      if (first_c < old_c) begin
         first_c = old_c;
      end
      lastp_c = (pos_c >= POS_W'(WIN_LEN - 1 - WIN_RADIUS)) ?
                POS_W'(WIN_LEN - 1) : pos_c + POS_W'(WIN_RADIUS);
      cnt_c   = CNT_W'(lastp_c) - CNT_W'(first_c) + CNT_W'(1);
      axis1_c = ang_ff[pos_c] <= ANGLE_SPLIT;
      sum_c   = '0;
      for (int i = 0; i < WIN_LEN; i++) begin
         ext_c = axis1_c ? box_ff[i].hi1 - box_ff[i].lo1 : box_ff[i].hi0 - box_ff[i].lo0;
         if (ext_c == '0) begin
            ext_c = COORD_W'(1);
         end
         if (POS_W'(i) >= first_c && POS_W'(i) <= lastp_c) begin
            sum_c = sum_c + SUM_W'(ext_c);
         end
      end
      ba_c = box_ff[pos_c];
      bb_c = (pos_c == POS_W'(WIN_LEN - 1)) ? box_ff[pos_c] : box_ff[pos_c + POS_W'(1)];
      if (ba_c.hi0 < bb_c.lo0) begin
         dx_c = bb_c.lo0 - ba_c.hi0;
      end else if (bb_c.hi0 < ba_c.lo0) begin
         dx_c = ba_c.lo0 - bb_c.hi0;
      end else begin
         dx_c = '0;
      end
      if (ba_c.hi1 < bb_c.lo1) begin
         dy_c = bb_c.lo1 - ba_c.hi1;
      end else if (bb_c.hi1 < ba_c.lo1) begin
         dy_c = ba_c.lo1 - bb_c.hi1;
      end else begin
         dy_c = '0;
      end
   end

   always_comb begin
      if (lhs_ff <= s2_ff) begin
         bnd_c = BND_SAME;
      end else if ({lhs_ff, 4'b0} < (S2_W + 4)'(prod_ff) ||
                   prod_ff[PROD_W-1:S2_W+4] != '0) begin
         bnd_c = BND_WORD;
      end else begin
         bnd_c = BND_PHRASE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (seen_ff >= IDX_W'(WIN_RADIUS) || req_data.last_box)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = (lag_ff == '0) ? ST_LOAD : ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = (last_ff && lag_ff != '0) ? ST_SETUP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = state_ff == ST_IDLE;
      req_fire  = req_valid && req_ready;
      load_fire = state_ff == ST_LOAD && out_free;
      op_a      = '0;
      op_b      = '0;
      unique case (step_ff)
         3'd0: begin
            op_a = MUL_A_W'(dx_ff);
            op_b = MUL_B_W'(dx_ff);
         end
         3'd1: begin
            op_a = MUL_A_W'(dy_ff);
            op_b = MUL_B_W'(dy_ff);
         end
         3'd2: begin
            op_a = MUL_A_W'(sum_ff);
            op_b = sum_ff;
         end
         3'd3: begin
            op_a = MUL_A_W'(cnt_ff);
            op_b = MUL_B_W'(cnt_ff);
         end
         3'd4: begin
            op_a = MUL_A_W'(d2_ff);
            op_b = prod_ff[MUL_B_W-1:0];
         end
         3'd5: begin
            op_a = MUL_A_W'(fac_ff);
            op_b = MUL_B_W'(fac_ff);
         end
         3'd6: begin
            op_a = s2_ff;
            op_b = prod_ff[MUL_B_W-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fac_ff       <= FAC_RESET;
         seen_ff      <= '0;
         word_ff      <= '0;
         phrase_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            fac_ff <= csr_data;
         end
         if (load_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            seen_ff <= req_data.last_box ? '0 :
                       (seen_ff == IDX_SAT) ? IDX_SAT : seen_ff + IDX_W'(1);
         end
         step_ff <= (state_ff == ST_MUL) ? step_ff + STEP_W'(1) : '0;
         if (load_fire) begin
            if (last_ff && lag_ff == '0) begin
               word_ff   <= '0;
               phrase_ff <= '0;
            end else begin
               if ((bnd_ff == BND_WORD || bnd_ff == BND_PHRASE) && word_ff != IDX_SAT) begin
                  word_ff <= word_ff + IDX_W'(1);
               end
               if (bnd_ff == BND_PHRASE && phrase_ff != IDX_SAT) begin
                  phrase_ff <= phrase_ff + IDX_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            box_ff[i] <= box_ff[i+1];
            ang_ff[i] <= ang_ff[i+1];
         end
         box_ff[WIN_LEN-1] <= new_box;
         ang_ff[WIN_LEN-1] <= req_data.line_angle;
         k_ff    <= seen_ff;
         last_ff <= req_data.last_box;
         lag_ff  <= (seen_ff >= IDX_W'(WIN_RADIUS)) ? LAG_W'(WIN_RADIUS) :
                    seen_ff[LAG_W-1:0];
      end
      if (state_ff == ST_SETUP) begin
         sum_ff <= sum_c;
         cnt_ff <= cnt_c;
         dx_ff  <= dx_c;
         dy_ff  <= dy_c;
         bnd_ff <= BND_NONE;
      end
      if (state_ff == ST_MUL) begin
         unique case (step_ff)
            3'd1: d2_ff <= prod_ff[D2_W-1:0];
            3'd2: d2_ff <= d2_ff + prod_ff[D2_W-1:0];
            3'd3: s2_ff <= prod_ff[S2_W-1:0];
            3'd5: lhs_ff <= prod_ff[S2_W-1:0];
            3'd7: bnd_ff <= bnd_c;
            default: begin
            end
         endcase
      end
      if (load_fire) begin
         rsp_ff.box_index    <= (k_ff == IDX_SAT) ? IDX_SAT : k_ff - IDX_W'(lag_ff);
         rsp_ff.boundary     <= bnd_ff;
         rsp_ff.word_index   <= word_ff;
         rsp_ff.phrase_index <= phrase_ff;
         rsp_ff.final_result <= bnd_ff == BND_NONE;
         if (last_ff && lag_ff != '0) begin
            lag_ff <= lag_ff - LAG_W'(1);
         end
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/cwpg_mul.sv
// Shared multiplier of the grouper with a registered product.
// Depends on cwpg_pkg.
`default_nettype none
module cwpg_mul
   import cwpg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] op_a,
   input  wire logic [MUL_B_W-1:0] op_b,
   output logic      [PROD_W-1:0]  prod_ff
);
   logic [MUL_A_W+MUL_B_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[PROD_W-1:0];
   end
endmodule
`default_nettype wire

>>> hw/rtl/cwpg_checker.sv
// Port-level checks for the grouper, bound to the top level.
// Depends on cwpg_pkg and collinear_word_phrase_grouper_unit.
`default_nettype none
module cwpg_checker
   import cwpg_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_final_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.final_result == (rsp_data.boundary == BND_NONE)))
      else $error("final flag and boundary disagree");
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("not ready after reset");
endmodule

bind collinear_word_phrase_grouper_unit cwpg_checker u_cwpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> sim/collinear_word_phrase_grouper_unit_tb.sv
// Testbench for the collinear word and phrase grouper unit.
// Drives box clusters with random gaps and stalls and checks each result against a local predictor.
// Depends on cwpg_pkg and the collinear_word_phrase_grouper_unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module collinear_word_phrase_grouper_unit_tb;
   import cwpg_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [FAC_W-1:0] csr_data = '0;

   localparam int CYCLE_LIMIT = 400000;

   collinear_word_phrase_grouper_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   box_type     win_box [WIN_LEN];
   logic [15:0] win_angle [WIN_LEN];
   int unsigned seen_count, word_count, phrase_count;
   int unsigned factor;
   rsp_type     grouping_queue [$];
   int          error_count = 0;
   int          rsp_count = 0;
   int          req_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;

   function automatic longint unsigned height_of(box_type b, bit axis);
      longint unsigned e;
      e = axis ? (b.hi1 - b.lo1) : (b.hi0 - b.lo0);
      return (e == 0) ? 1 : e;
   endfunction

   function automatic longint unsigned gap_of(logic [15:0] la, logic [15:0] ha,
                                              logic [15:0] lb, logic [15:0] hb);
      if (ha < lb) return lb - ha;
      if (hb < la) return la - hb;
      return 0;
   endfunction

   function automatic logic [1:0] boundary_of(int p, int oldest);
      bit axis;
      int first, lastp;
      longint unsigned sum, cnt, dx, dy, lhs, rhs;
      if (p >= WIN_LEN - 1) return BND_NONE;
      axis = (win_angle[p] <= ANGLE_SPLIT);
      first = (p >= WIN_RADIUS) ? p - WIN_RADIUS : 0;
      if (first < oldest) first = oldest;
      lastp = (p + WIN_RADIUS > WIN_LEN - 1) ? WIN_LEN - 1 : p + WIN_RADIUS;
      sum = 0;
      for (int i = first; i <= lastp; i++) sum += height_of(win_box[i], axis);
      cnt = lastp - first + 1;
      dx = gap_of(win_box[p].lo0, win_box[p].hi0, win_box[p+1].lo0, win_box[p+1].hi0);
      dy = gap_of(win_box[p].lo1, win_box[p].hi1, win_box[p+1].lo1, win_box[p+1].hi1);
      lhs = (dx * dx + dy * dy) * cnt * cnt;
      rhs = sum * sum;
      if (lhs <= rhs) return BND_SAME;
      if (16 * lhs < factor * factor * rhs) return BND_WORD;
      return BND_PHRASE;
   endfunction

   function automatic int unsigned sat_inc(int unsigned v);
      return (v >= 65535) ? 65535 : v + 1;
   endfunction

   function automatic void push_grouping(int lag, int unsigned k);
      rsp_type r;
      int filled;
      filled = (k < WIN_LEN - 1) ? k : WIN_LEN - 1;
      r.boundary = boundary_of(WIN_LEN - 1 - lag, WIN_LEN - 1 - filled);
      r.box_index = (k >= 65535) ? 16'hFFFF : 16'(k - lag);
      r.word_index = 16'(word_count);
      r.phrase_index = 16'(phrase_count);
      r.final_result = (r.boundary == BND_NONE);
      grouping_queue = {grouping_queue, r};
      if (r.boundary != BND_SAME && r.boundary != BND_NONE) word_count = sat_inc(word_count);
      if (r.boundary == BND_PHRASE) phrase_count = sat_inc(phrase_count);
   endfunction

   function automatic void predict_grouping(req_type q);
      box_type b;
      int unsigned k;
      b.lo0 = (q.min_first < q.max_first) ? q.min_first : q.max_first;
      b.hi0 = (q.min_first < q.max_first) ? q.max_first : q.min_first;
      b.lo1 = (q.min_second < q.max_second) ? q.min_second : q.max_second;
      b.hi1 = (q.min_second < q.max_second) ? q.max_second : q.min_second;
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         win_box[i] = win_box[i+1];
         win_angle[i] = win_angle[i+1];
      end
      win_box[WIN_LEN-1] = b;
      win_angle[WIN_LEN-1] = q.line_angle;
      k = seen_count;
      if (k >= WIN_RADIUS) push_grouping(WIN_RADIUS, k);
      if (q.last_box) begin
         for (int d = (k >= WIN_RADIUS) ? WIN_RADIUS - 1 : k; d >= 0; d--)
            push_grouping(d, k);
         seen_count = 0;
         word_count = 0;
         phrase_count = 0;
      end else begin
         seen_count = sat_inc(seen_count);
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %0s at result %0d: got %0d want %0d", what, rsp_count, got, want);
      error_count++;
   endtask

   task automatic idle_cycles();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_box(req_type q);
      idle_cycles();
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_grouping(q);
      req_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (grouping_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_factor(int unsigned f);
      drain();
      csr_valid <= 1'b1;
      csr_data <= FAC_W'(f);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      factor = f;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_box(int unsigned x, int unsigned y, int unsigned w,
                                        int unsigned h, logic [15:0] ang, bit last);
      req_type q;
      q.min_first = 16'(x);
      q.max_first = 16'(x + w);
      q.min_second = 16'(y);
      q.max_second = 16'(y + h);
      q.line_angle = ang;
      q.last_box = last;
      return q;
   endfunction

   task automatic send_cluster(int n, bit vertical);
      int unsigned pos, h;
      logic [15:0] ang;
      pos = $urandom_range(0, 20000);
      h = $urandom_range(0, 40);
      ang = vertical ? 16'($urandom_range(12868, 51472)) : 16'($urandom_range(0, 12867));
      for (int i = 0; i < n; i++) begin
         int unsigned w;
         req_type q;
         w = $urandom_range(0, 60);
         if (vertical) q = make_box($urandom_range(0, 3), pos, h, w, ang, i == n - 1);
         else q = make_box(pos, $urandom_range(0, 3), w, h + $urandom_range(0, 4), ang,
                           i == n - 1);
         if ($urandom_range(0, 7) == 0) begin
            logic [15:0] t;
            t = q.min_first; q.min_first = q.max_first; q.max_first = t;
         end
         send_box(q);
         case ($urandom_range(0, 3))
            0: pos += w;
            1: pos += w + $urandom_range(1, h + 2);
            2: pos += w + $urandom_range(h, 3 * h + 10);
            default: pos += w + $urandom_range(0, 300);
         endcase
         pos = pos % 60000;
      end
   endtask

   task automatic test_extremes();
      send_box(make_box(0, 0, 0, 0, 16'd0, 1'b1));
      send_box(make_box(0, 0, 0, 0, 16'd12867, 1'b0));
      send_box(make_box(1, 0, 0, 0, 16'd0, 1'b1));
      send_box(make_box(0, 0, 0, 0, 16'd12868, 1'b0));
      send_box(make_box(65535, 65535, 0, 0, 16'hFFFF, 1'b0));
      send_box('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd51472, 1'b1});
      send_box('{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0});
      send_box('{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 1'b0});
      send_box('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'd100, 1'b0});
      send_box('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd30000, 1'b1});
   endtask

   task automatic test_boundaries();
      send_box(make_box(0, 0, 10, 10, 16'd0, 1'b0));
      send_box(make_box(5, 0, 10, 10, 16'd0, 1'b0));
      send_box(make_box(25, 0, 10, 10, 16'd0, 1'b0));
      send_box(make_box(50, 0, 10, 10, 16'd0, 1'b0));
      send_box(make_box(200, 200, 10, 10, 16'd0, 1'b0));
      send_box(make_box(210, 210, 10, 10, 16'd0, 1'b1));
   endtask

   task automatic test_factor_settings();
      int unsigned fs [5] = '{31, 0, 4, 3, 17};
      foreach (fs[i]) begin
         write_factor(fs[i]);
         repeat (4) send_cluster($urandom_range(1, 9), $urandom_range(0, 1));
      end
      write_factor(10);
   endtask

   task automatic test_random_clusters();
      while (req_count < 370) begin
         if ($urandom_range(0, 9) == 0) begin
            req_type q;
            q = req_type'({$urandom, $urandom, $urandom, 1'($urandom)});
            send_box(q);
         end else begin
            send_cluster($urandom_range(1, 12), $urandom_range(0, 1));
         end
         if ($urandom_range(0, 30) == 0) drain();
      end
   endtask

   task automatic test_back_to_back();
      calm = 1'b1;
      repeat (8) send_cluster($urandom_range(2, 10), $urandom_range(0, 1));
      send_box(make_box(7, 7, 3, 3, 16'd5, 1'b1));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (grouping_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.box_index, -1);
         end else begin
            rsp_type want;
            want = grouping_queue.pop_front();
            if (rsp_data.box_index !== want.box_index)
               report_mismatch("box_index", rsp_data.box_index, want.box_index);
            if (rsp_data.boundary !== want.boundary)
               report_mismatch("boundary", rsp_data.boundary, want.boundary);
            if (rsp_data.word_index !== want.word_index)
               report_mismatch("word_index", rsp_data.word_index, want.word_index);
            if (rsp_data.phrase_index !== want.phrase_index)
               report_mismatch("phrase_index", rsp_data.phrase_index, want.phrase_index);
            if (rsp_data.final_result !== want.final_result)
               report_mismatch("final_result", rsp_data.final_result, want.final_result);
         end
         rsp_count++;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      factor = FAC_RESET;
      seen_count = 0;
      word_count = 0;
      phrase_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_boundaries();
      test_factor_settings();
      test_random_clusters();
      test_back_to_back();
      drain();
      $display("sent %0d boxes, checked %0d results across factor settings 0 to 31",
               req_count, rsp_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/cwpg_pkg.sv
hw/rtl/cwpg_mul.sv
hw/rtl/collinear_word_phrase_grouper_unit.sv
hw/rtl/cwpg_checker.sv
sim/collinear_word_phrase_grouper_unit_tb.sv
